// ===== rtl/sha1mh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1mh_pkg
// Shared types, constants and round functions for the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

  // Default depth of the queue between front end and hashing core
  localparam int unsigned QueueDepthDef = 4;

  // Number of chaining words and compression rounds
  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumRounds = 80;

  // One classified word handed from the front end to the core
  typedef struct packed {
    logic [7:0]  byte_val;  // data byte, already masked and marked if final with spare bits
    logic        start;     // first word of a message
    logic        last;      // final word of a message
    logic        need_pad;  // final byte was whole: a 0x80 marker byte follows
    logic [31:0] bit_len;   // running message length in bits (valid on last)
    logic        too_long;  // length passed 2^32-1 bits (valid on last)
  } q_entry_t;

  // Core sequencer states
  typedef enum logic [2:0] {
    ST_DATA,   // take message words from the queue
    ST_PAD,    // insert marker, zero and length bytes
    ST_ROUND,  // one compression round per cycle
    ST_ADD,    // fold working words into the chaining words
    ST_OUT     // present the five digest words
  } core_state_e;

  // SHA-1 initial chaining words
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] val;
    case (idx)
      3'd0:    val = 32'h67452301;
      3'd1:    val = 32'hefcdab89;
      3'd2:    val = 32'h98badcfe;
      3'd3:    val = 32'h10325476;
      3'd4:    val = 32'hc3d2e1f0;
      default: val = 32'h0;
    endcase
    return val;
  endfunction

  // Round constant
  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] val;
    if (rnd < 7'd20)      val = 32'h5a827999;
    else if (rnd < 7'd40) val = 32'h6ed9eba1;
    else if (rnd < 7'd60) val = 32'h8f1bbcdc;
    else                  val = 32'hca62c1d6;
    return val;
  endfunction

  // Round boolean function: choose, parity, majority, parity
  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] val;
    if (rnd < 7'd20)      val = (b & c) | (~b & d);
    else if (rnd < 7'd40) val = b ^ c ^ d;
    else if (rnd < 7'd60) val = (b & c) | (b & d) | (c & d);
    else                  val = b ^ c ^ d;
    return val;
  endfunction

endpackage

// ===== rtl/sha1mh_front.sv =====
// ----------------------------------------------------------------------------
// sha1mh_front
// Accepts message bytes, masks and marks the final byte, keeps the running bit
// length and overflow flag, and queues classified words for the core.
// ----------------------------------------------------------------------------
module sha1mh_front
  import sha1mh_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       message_start_i,
  input  logic       message_end_i,
  input  logic [2:0] spare_bits_i,
  // queue head towards the core
  output logic       head_valid_o,
  output q_entry_t   head_o,
  input  logic       head_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [31:0]   bit_cnt_q;
  logic          ovf_q;
  q_entry_t      entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic          push, pop;
  logic [2:0]    ub;
  logic [3:0]    nbits;
  logic [31:0]   base_cnt;
  logic          base_ovf;
  logic [32:0]   sum;
  q_entry_t      entry;

  assign in_stall_o   = (count_q == CntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign pop          = head_pop_i && head_valid_o;
  assign head_o       = entries_q[rd_ptr_q];

  // classify the incoming byte and extend the bit length
  always_comb begin
    ub       = message_end_i ? spare_bits_i : 3'd0;
    nbits    = 4'd8 - {1'b0, ub};
    base_cnt = message_start_i ? 32'd0 : bit_cnt_q;
    base_ovf = message_start_i ? 1'b0 : ovf_q;
    sum      = {1'b0, base_cnt} + {29'd0, nbits};

    entry.byte_val = data_byte_i;
    entry.start    = message_start_i;
    entry.last     = message_end_i;
    entry.need_pad = message_end_i && (ub == 3'd0);
    entry.bit_len  = sum[31:0];
    entry.too_long = base_ovf | sum[32];
    // final byte with unused bits: clear them, marker bit right below the data
    if (message_end_i && (ub != 3'd0)) begin
      entry.byte_val = (data_byte_i & (8'hFF << ub)) | (8'h01 << (ub - 3'd1));
    end
  end

  // length tracking, cleared once the final byte has gone by
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      ovf_q     <= 1'b0;
    end else if (push) begin
      if (message_end_i) begin
        bit_cnt_q <= '0;
        ovf_q     <= 1'b0;
      end else begin
        bit_cnt_q <= sum[31:0];
        ovf_q     <= entry.too_long;
      end
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue fill count beyond depth");

  a_len_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && message_end_i) |=> (bit_cnt_q == '0 && !ovf_q))
    else $error("bit length not cleared after final byte");

endmodule

// ===== rtl/sha1mh_core.sv =====
// ----------------------------------------------------------------------------
// sha1mh_core
// Packs queued bytes big-endian into a 16-word schedule line, adds padding
// and length, runs the 80 SHA-1 rounds one per cycle and emits the digest.
// ----------------------------------------------------------------------------
module sha1mh_core
  import sha1mh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // queue head from the front end
  input  logic        head_valid_i,
  input  q_entry_t    head_i,
  output logic        head_pop_o,
  // digest channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o,
  output logic        too_long_o
);

  core_state_e state_q, state_d;
  logic [5:0]  pos_q, pos_d, pos_eff;
  logic [23:0] acc_q, acc_d;
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] chain_q [NumChain];
  logic [31:0] chain_d [NumChain];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [6:0]  rnd_q, rnd_d;
  logic        need80_q, need80_d;
  logic        wrap_q, wrap_d;
  logic        pad_mode_q, pad_mode_d;
  logic        final_q, final_d;
  logic [31:0] len_q, len_d;
  logic        ovf_q, ovf_d;
  logic [2:0]  idx_q, idx_d;

  logic        put_en;
  logic [7:0]  put_val;
  logic [31:0] sched_new;
  logic [31:0] round_t;

  // message schedule word and round sum
  assign sched_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                      w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign round_t   = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
                     + w_q[0] + round_k(rnd_q);

  // digest outputs straight from the chaining registers
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[idx_q];
  assign digest_last_o = (idx_q == 3'd4);
  assign too_long_o    = ovf_q;

  // sequencer and datapath next values
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    pos_eff    = pos_q;
    acc_d      = acc_q;
    w_d        = w_q;
    chain_d    = chain_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    d_d        = d_q;
    e_d        = e_q;
    rnd_d      = rnd_q;
    need80_d   = need80_q;
    wrap_d     = wrap_q;
    pad_mode_d = pad_mode_q;
    final_d    = final_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    head_pop_o = 1'b0;
    put_en     = 1'b0;
    put_val    = 8'h00;

    unique case (state_q)
      ST_DATA: begin
        if (head_valid_i) begin
          head_pop_o = 1'b1;
          put_en     = 1'b1;
          put_val    = head_i.byte_val;
          // new message: drop buffered bytes, reload initial words
          if (head_i.start) begin
            pos_eff = '0;
            for (int i = 0; i < NumChain; i++) chain_d[i] = iv_word(3'(i));
          end
          if (head_i.last) begin
            pad_mode_d = 1'b1;
            need80_d   = head_i.need_pad;
            len_d      = head_i.bit_len;
            ovf_d      = head_i.too_long;
            // marker landed in the length field: zero-fill to a new block
            wrap_d     = !head_i.need_pad && (pos_eff >= 6'd56) && (pos_eff != 6'd63);
            state_d    = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        put_en = 1'b1;
        if (need80_q) begin
          put_val  = 8'h80;
          need80_d = 1'b0;
          wrap_d   = (pos_q >= 6'd56) && (pos_q != 6'd63);
        end else if (!wrap_q && (pos_q[5:2] == 4'd15)) begin
          case (pos_q[1:0])
            2'd0:    put_val = len_q[31:24];
            2'd1:    put_val = len_q[23:16];
            2'd2:    put_val = len_q[15:8];
            default: put_val = len_q[7:0];
          endcase
        end else begin
          put_val = 8'h00;
        end
        if (wrap_q && (pos_q == 6'd63)) wrap_d = 1'b0;
        // last length byte closes the final block
        if (!need80_q && !wrap_q && (pos_q == 6'd63)) final_d = 1'b1;
      end

      ST_ROUND: begin
        a_d   = round_t;
        b_d   = a_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        d_d   = c_q;
        e_d   = d_q;
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = sched_new;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == 7'(NumRounds - 1)) state_d = ST_ADD;
      end

      ST_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        if (final_q) begin
          idx_d   = 3'd0;
          state_d = ST_OUT;
        end else if (pad_mode_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_DATA;
        end
      end

      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 1'b1;
          // digest gone: restart for the next message
          if (idx_q == 3'd4) begin
            for (int i = 0; i < NumChain; i++) chain_d[i] = iv_word(3'(i));
            pos_d      = '0;
            pad_mode_d = 1'b0;
            final_d    = 1'b0;
            wrap_d     = 1'b0;
            need80_d   = 1'b0;
            idx_d      = 3'd0;
            state_d    = ST_DATA;
          end
        end
      end

      default: state_d = ST_DATA;
    endcase

    // byte packing into the schedule line; a full block starts the rounds
    if (put_en) begin
      acc_d = {acc_q[15:0], put_val};
      if (pos_eff[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = {acc_q, put_val};
      end
      pos_d = pos_eff + 1'b1;
      if (pos_eff == 6'd63) begin
        rnd_d   = '0;
        a_d     = chain_q[0];
        b_d     = chain_q[1];
        c_d     = chain_q[2];
        d_d     = chain_q[3];
        e_d     = chain_q[4];
        state_d = ST_ROUND;
      end
    end
  end

  // control registers and chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_DATA;
      pos_q      <= '0;
      rnd_q      <= '0;
      need80_q   <= 1'b0;
      wrap_q     <= 1'b0;
      pad_mode_q <= 1'b0;
      final_q    <= 1'b0;
      ovf_q      <= 1'b0;
      idx_q      <= '0;
      for (int i = 0; i < NumChain; i++) chain_q[i] <= iv_word(3'(i));
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      rnd_q      <= rnd_d;
      need80_q   <= need80_d;
      wrap_q     <= wrap_d;
      pad_mode_q <= pad_mode_d;
      final_q    <= final_d;
      ovf_q      <= ovf_d;
      idx_q      <= idx_d;
      chain_q    <= chain_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    w_q   <= w_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
    len_q <= len_d;
  end

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rnd_q < 7'(NumRounds)))
    else $error("round counter out of range");

  a_pop_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> (state_q == ST_DATA && head_valid_i))
    else $error("queue popped outside data state");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && digest_last_o) |=>
      (state_q == ST_DATA && pos_q == '0 && !pad_mode_q && chain_q[0] == iv_word(3'd0)))
    else $error("core not restarted after digest");

endmodule

// ===== rtl/sha1_message_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha1_message_hasher_top
// Streaming SHA-1 hasher: message bytes in, five 32-bit digest words out.
// ----------------------------------------------------------------------------
// Input channel: one message byte per word, most significant bit first, with
// message_start on the first byte and message_end plus spare_bits on the
// last. A word is taken when in_valid_i is high and in_stall_o is low.
// Output channel: five digest words per message, word 0 first, digest_last_o
// on the fifth, too_long_o on all five when the length passed 2^32-1 bits.
// Flow: the front end queues up to QueueDepth bytes while the core works.
// The core packs one byte per cycle while the queue holds bytes; every 64th
// byte starts 80 rounds at one per cycle and then a fold into the chaining
// words, during which the core takes no new bytes. After the final byte the
// core inserts padding and length bytes at one per cycle, with a possible
// extra block, runs the last compression and then offers the digest words,
// one per cycle while out_stall_i is low.
// Reset loads the initial chaining words and empties the queue; no clearing
// pass is needed. While out_stall_i is high the digest word holds, the core
// waits, and the queue keeps taking bytes until it is full.
// ----------------------------------------------------------------------------
module sha1_message_hasher_top
  import sha1mh_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        message_start_i,
  input  logic        message_end_i,
  input  logic [2:0]  spare_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o,
  output logic        too_long_o
);

  logic     head_valid;
  logic     head_pop;
  q_entry_t head;

  // byte classification and queue
  sha1mh_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .message_end_i   (message_end_i),
    .spare_bits_i    (spare_bits_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .head_pop_i      (head_pop)
  );

  // packing, padding, compression and digest output
  sha1mh_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_pop_o    (head_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .digest_last_o (digest_last_o),
    .too_long_o    (too_long_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming SHA-1 hasher. A short table of
// directed words (one known digest, single-bit and partial-byte messages,
// restarts mid-message) is followed by random messages of mixed length,
// with block-boundary lengths favoured. Each accepted word runs through a
// local SHA-1 model; every digest word taken from the block is compared
// with the oldest predicted one. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned NumRows = 18;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  // One expected digest word
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        too_long;
  } digest_beat_t;

  // One row of the directed table; known_ok marks a digest typed in by hand
  typedef struct packed {
    logic [7:0]   data;
    logic         start;
    logic         fin;
    logic [2:0]   spare;
    logic         known_ok;
    logic [159:0] known;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        message_start_i = 1'b0;
  logic        message_end_i = 1'b0;
  logic [2:0]  spare_bits_i = 3'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        digest_last_o;
  logic        too_long_o;

  // Model state
  logic [31:0] chain_q [5];
  logic [31:0] blk_q [16];
  int unsigned pos_q;
  logic [31:0] bitlen_q;
  bit          ovf_q;
  logic [31:0] sha_out [5];
  bit          sha_ovf;
  bit          digest_ready;

  digest_beat_t digest_due_q [$];
  int unsigned  err_cnt = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  words_pushed = 0;
  int unsigned  cycle_cnt = 0;
  bit           msg_open = 1'b0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned phase_cnt = 0;
  int unsigned hold_cnt = 0;

  // "abc" is the one digest given by hand
  dir_row_t dir_rows [NumRows] = '{
    '{8'h61, 1'b1, 1'b0, 3'd0, 1'b0, 160'h0},
    '{8'h62, 1'b0, 1'b0, 3'd0, 1'b0, 160'h0},
    '{8'h63, 1'b0, 1'b1, 3'd0, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
    '{8'hff, 1'b1, 1'b1, 3'd7, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b1, 3'd0, 1'b0, 160'h0},
    '{8'ha5, 1'b1, 1'b0, 3'd0, 1'b0, 160'h0},
    '{8'h5a, 1'b0, 1'b0, 3'd0, 1'b0, 160'h0},
    '{8'h3c, 1'b1, 1'b0, 3'd0, 1'b0, 160'h0},
    '{8'hc3, 1'b0, 1'b1, 3'd3, 1'b0, 160'h0},
    '{8'h12, 1'b1, 1'b0, 3'd5, 1'b0, 160'h0},
    '{8'hff, 1'b0, 1'b1, 3'd1, 1'b0, 160'h0},
    '{8'h80, 1'b1, 1'b1, 3'd0, 1'b0, 160'h0},
    '{8'h7f, 1'b1, 1'b0, 3'd2, 1'b0, 160'h0},
    '{8'h01, 1'b0, 1'b1, 3'd7, 1'b0, 160'h0},
    '{8'hff, 1'b1, 1'b1, 3'd0, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 3'd4, 1'b0, 160'h0},
    '{8'h55, 1'b0, 1'b1, 3'd6, 1'b0, 160'h0},
    '{8'haa, 1'b1, 1'b1, 3'd5, 1'b0, 160'h0}
  };

  sha1_message_hasher_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .message_end_i   (message_end_i),
    .spare_bits_i    (spare_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_word_o   (digest_word_o),
    .digest_last_o   (digest_last_o),
    .too_long_o      (too_long_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // 80 rounds over the current block into the chaining words
  task automatic sha_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int          r;
    for (r = 0; r < 16; r++) w[r] = blk_q[r];
    for (r = 16; r < 80; r++) w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (r = 0; r < 80; r++) begin
      case (r / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = 32'h5a827999;
        end
        1: begin
          f = b ^ c ^ d;
          k = 32'h6ed9eba1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8f1bbcdc;
        end
        default: begin
          f = b ^ c ^ d;
          k = 32'hca62c1d6;
        end
      endcase
      t = rotl(a, 5) + f + e + w[r] + k;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c;
    chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic load_iv();
    chain_q = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
    pos_q = 0;
    bitlen_q = '0;
    ovf_q = 1'b0;
  endtask

  // Big-endian packing; a full block is compressed at once
  task automatic pack_byte(input logic [7:0] v);
    int unsigned idx, sh;
    idx = pos_q >> 2;
    sh = 24 - 8 * (pos_q & 3);
    blk_q[idx] = (blk_q[idx] & ~(32'hff << sh)) | ({24'h0, v} << sh);
    pos_q++;
    if (pos_q == 64) begin
      sha_compress();
      pos_q = 0;
    end
  endtask

  // One accepted word; sets digest_ready when a digest falls out
  task automatic hash_byte(input logic [7:0] b, input bit s, input bit fin,
                           input logic [2:0] ub);
    logic [2:0]  spare;
    logic [32:0] total;
    digest_ready = 1'b0;
    if (s) load_iv();
    // unused bits count only on the final byte
    spare = fin ? ub : 3'd0;
    total = {1'b0, bitlen_q} + (33'd8 - spare);
    if (total[32]) ovf_q = 1'b1;
    bitlen_q = total[31:0];
    if (!fin) begin
      pack_byte(b);
      return;
    end
    // marker bit sits right after the last data bit
    if (spare != 3'd0) begin
      pack_byte((b & (8'hff << spare)) | (8'h01 << (spare - 3'd1)));
    end else begin
      pack_byte(b);
      pack_byte(8'h80);
    end
    while (pos_q != 56) pack_byte(8'h00);
    blk_q[14] = '0;
    blk_q[15] = bitlen_q;
    sha_compress();
    sha_out = chain_q;
    sha_ovf = ovf_q;
    digest_ready = 1'b1;
    load_iv();
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word, wait for it to be taken, then predict
  task automatic send_byte(input logic [7:0] b, input bit s, input bit fin,
                           input logic [2:0] ub, input bit known_ok,
                           input logic [159:0] known, input int unsigned gap);
    bit           took;
    digest_beat_t beat;
    int           j;
    data_byte_i <= b;
    message_start_i <= s;
    message_end_i <= fin;
    spare_bits_i <= ub;
    in_valid_i <= 1'b1;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end
    bytes_sent++;
    hash_byte(b, s, fin, ub);
    if (digest_ready) begin
      for (j = 0; j < 5; j++) begin
        beat.word = known_ok ? known[159 - 32 * j -: 32] : sha_out[j];
        beat.last = (j == 4);
        beat.too_long = sha_ovf;
        digest_due_q.push_back(beat);
        words_pushed++;
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly well-formed messages; some cut short or restarted part-way
  task automatic send_random_message();
    int unsigned len, cut, i;
    bit          lead, fast, trunc, s, fin;
    logic [2:0]  ub;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = $urandom_range(1, 12);
      5, 6:          len = $urandom_range(13, 40);
      7, 8: begin
        case ($urandom_range(0, 5))
          0:       len = 55;
          1:       len = 56;
          2:       len = 63;
          3:       len = 64;
          4:       len = 65;
          default: len = 119;
        endcase
      end
      default:       len = $urandom_range(41, 130);
    endcase
    trunc = ($urandom_range(0, 9) == 0);
    cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
    // a message after a clean digest may leave out its start flag
    lead = msg_open || ($urandom_range(0, 4) != 0);
    fast = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      s = (i == 0 && lead) || (cut != 0 && i == cut);
      fin = !trunc && (i == len - 1);
      if (fin) ub = 3'($urandom_range(0, 7));
      else ub = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
      send_byte(8'($urandom_range(0, 255)), s, fin, ub, 1'b0, '0,
                fast ? 0 : pick_gap());
    end
    msg_open = trunc;
  endtask

  // ---------------------------------------------------------------- receiver

  // Output stall in phases: none, light, heavy with long holds
  always @(posedge clk_i) begin
    if (phase_cnt == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      phase_cnt <= $urandom_range(20, 120);
    end else begin
      phase_cnt <= phase_cnt - 1;
    end
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (stall_mode != STALL_NONE && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      if (stall_mode == STALL_HEAVY && $urandom_range(0, 4) == 0)
        hold_cnt <= $urandom_range(10, 40);
      else
        hold_cnt <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Digest check, sampled mid-cycle where all signals are settled
  always @(negedge clk_i) begin : digest_mon
    digest_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_due_q.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, digest_word_o);
        err_cnt++;
      end else begin
        want = digest_due_q.pop_front();
        if (digest_word_o !== want.word) begin
          $display("%0t: digest_word expected %h got %h", $time, want.word, digest_word_o);
          err_cnt++;
        end
        if (digest_last_o !== want.last) begin
          $display("%0t: digest_last expected %b got %b", $time, want.last, digest_last_o);
          err_cnt++;
        end
        if (too_long_o !== want.too_long) begin
          $display("%0t: too_long expected %b got %b", $time, want.too_long, too_long_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main

  initial begin : main
    int unsigned i;
    blk_q = '{default: '0};
    load_iv();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < NumRows; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].fin,
                dir_rows[i].spare, dir_rows[i].known_ok, dir_rows[i].known,
                pick_gap());
    end

    // random messages
    while (bytes_sent < 230 || words_pushed < 40) send_random_message();
    in_valid_i <= 1'b0;

    while (digest_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sha1mh_pkg.sv
rtl/sha1mh_front.sv
rtl/sha1mh_core.sv
rtl/sha1_message_hasher_top.sv
sim/tb_top.sv
